[hdl/fmt_pkg.sv]
// ----------------------------------------------------------------------------
// fmt_pkg
// Shared sizes, codes and controller types of the A times A-transpose engine.
// ----------------------------------------------------------------------------
package fmt_pkg;

  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;

  localparam int ADDR_W   = 12;
  localparam int DATA_W   = 32;
  localparam int KIND_W   = 2;
  localparam int DIM_REG_W = 7;

  localparam int A_DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int C_DEPTH  = MAX_ROWS * MAX_ROWS;
  localparam int A_AW     = $clog2(A_DEPTH);
  localparam int C_AW     = $clog2(C_DEPTH);

  localparam int IDX_W    = $clog2(MAX_ROWS);
  localparam int K_W      = $clog2(MAX_COLS);
  localparam int ROWS_W   = $clog2(MAX_ROWS + 1);
  localparam int COLS_W   = $clog2(MAX_COLS + 1);

  localparam logic [DATA_W-1:0] QNAN = 32'h7FC0_0000;

  localparam logic [7:0] CFG_ROWS = 8'd0;
  localparam logic [7:0] CFG_COLS = 8'd1;

  typedef enum logic [KIND_W-1:0] {
    KIND_WR_A    = 2'd0,
    KIND_WR_C    = 2'd1,
    KIND_COMPUTE = 2'd2,
    KIND_RD_C    = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CRD,
    ST_CLD,
    ST_ARD,
    ST_MUL,
    ST_MRND,
    ST_ADD,
    ST_ARND,
    ST_CWR
  } state_e;

  typedef struct packed {
    logic c_rd;
    logic acc_ld_c;
    logic a_rd;
    logic acc_ld_sum;
    logic c_wr;
    logic k_clr;
    logic k_inc;
    logic ij_clr;
    logic ij_inc;
  } cmd_t;

  typedef struct packed {
    logic last_k;
    logic last_i;
    logic last_j;
  } stat_t;

endpackage

[hdl/fmt_fpu.sv]
// ----------------------------------------------------------------------------
// fmt_fpu
// Binary32 multiply and add, round to nearest even, subnormals kept.
// Four register stages: product raw, product rounded, sum raw, sum rounded
// (the last one is the accumulator in the datapath).
// ----------------------------------------------------------------------------
module fmt_fpu import fmt_pkg::*; (
  input  logic              clk_i,
  input  logic [DATA_W-1:0] op_x_i,
  input  logic [DATA_W-1:0] op_y_i,
  input  logic [DATA_W-1:0] acc_i,
  output logic [DATA_W-1:0] sum_o
);

  typedef struct packed {
    logic               nan;
    logic               inf;
    logic               sgn;
    logic [47:0]        sig;
    logic signed [10:0] expo;
  } raw_t;

  // sig bit 46 carries weight 2^(expo - bias)
  function automatic logic [31:0] fp_round(input logic sgn, input logic [47:0] sig,
                                           input logic signed [10:0] expo);
    logic [5:0]         lz;
    logic signed [10:0] e_msb;
    logic [47:0]        sh;
    logic               st_r;
    logic [10:0]        rsh;
    logic [7:0]         ef;
    logic [30:0]        pk;
    logic               inc;
    logic               ovf;
    lz = 6'd48;
    for (int b = 0; b < 48; b++) begin
      if (sig[b]) lz = 6'(47 - b);
    end
    e_msb = expo + 11'sd1 - signed'({5'd0, lz});
    st_r  = 1'b0;
    ef    = 8'd0;
    ovf   = 1'b0;
    sh    = sig;
    rsh   = 11'd0;
    if (sig == 48'd0) return {sgn, 31'd0};
    if (e_msb >= 1) begin
      sh  = sig << lz;
      ovf = (e_msb >= 255);
      ef  = e_msb[7:0];
    end else if (expo >= 0) begin
      // subnormal: bit 47 lands on the minimum exponent
      sh = sig << expo[5:0];
    end else begin
      rsh = 11'(-expo);
      if (rsh >= 11'd48) begin
        sh   = 48'd0;
        st_r = 1'b1;
      end else begin
        sh   = sig >> rsh;
        st_r = |(sig & ~({48{1'b1}} << rsh));
      end
    end
    if (ovf) return {sgn, 8'hFF, 23'd0};
    inc = sh[23] & (st_r | (|sh[22:0]) | sh[24]);
    // carry out of the fraction moves into the exponent field
    pk = {ef, sh[46:24]} + 31'(inc);
    return {sgn, pk};
  endfunction

  function automatic logic [31:0] fp_finish(input raw_t r);
    if (r.nan) return QNAN;
    if (r.inf) return {r.sgn, 8'hFF, 23'd0};
    return fp_round(r.sgn, r.sig, r.expo);
  endfunction

  raw_t              mraw_d, mraw_q;
  raw_t              araw_d, araw_q;
  logic [DATA_W-1:0] prod_q;

  // multiply, stage one
  always_comb begin
    logic [7:0]  ex, ey;
    logic        xn, yn, xi, yi, xz, yz;
    logic [23:0] mx, my;
    logic signed [10:0] exx, eyy;
    ex  = op_x_i[30:23];
    ey  = op_y_i[30:23];
    xn  = (ex == 8'hFF) && (op_x_i[22:0] != 23'd0);
    yn  = (ey == 8'hFF) && (op_y_i[22:0] != 23'd0);
    xi  = (ex == 8'hFF) && (op_x_i[22:0] == 23'd0);
    yi  = (ey == 8'hFF) && (op_y_i[22:0] == 23'd0);
    xz  = (op_x_i[30:0] == 31'd0);
    yz  = (op_y_i[30:0] == 31'd0);
    mx  = {ex != 8'd0, op_x_i[22:0]};
    my  = {ey != 8'd0, op_y_i[22:0]};
    exx = (ex == 8'd0) ? 11'sd1 : signed'({3'd0, ex});
    eyy = (ey == 8'd0) ? 11'sd1 : signed'({3'd0, ey});
    mraw_d.nan  = xn | yn | (xi & yz) | (yi & xz);
    mraw_d.inf  = xi | yi;
    mraw_d.sgn  = op_x_i[31] ^ op_y_i[31];
    mraw_d.sig  = mx * my;
    mraw_d.expo = exx + eyy - 11'sd127;
  end

  // add, stage one: align the smaller magnitude
  always_comb begin
    logic [31:0] bg, sm;
    logic [7:0]  eb, es;
    logic        bn, sn, bi, si;
    logic [23:0] mb, ms;
    logic signed [10:0] ebb, ess, diff;
    logic [47:0] big, small_v, shd, sum;
    logic        st;
    if (prod_q[30:0] > acc_i[30:0]) begin
      bg = prod_q;
      sm = acc_i;
    end else begin
      bg = acc_i;
      sm = prod_q;
    end
    eb  = bg[30:23];
    es  = sm[30:23];
    bn  = (eb == 8'hFF) && (bg[22:0] != 23'd0);
    sn  = (es == 8'hFF) && (sm[22:0] != 23'd0);
    bi  = (eb == 8'hFF) && (bg[22:0] == 23'd0);
    si  = (es == 8'hFF) && (sm[22:0] == 23'd0);
    mb  = {eb != 8'd0, bg[22:0]};
    ms  = {es != 8'd0, sm[22:0]};
    ebb = (eb == 8'd0) ? 11'sd1 : signed'({3'd0, eb});
    ess = (es == 8'd0) ? 11'sd1 : signed'({3'd0, es});
    diff = ebb - ess;
    big     = {1'b0, mb, 23'd0};
    small_v = {1'b0, ms, 23'd0};
    if (diff >= 48) begin
      shd = 48'd0;
      st  = |ms;
    end else begin
      shd = small_v >> diff[5:0];
      st  = |(small_v & ~({48{1'b1}} << diff[5:0]));
    end
    shd[0] = shd[0] | st;
    sum = (bg[31] ^ sm[31]) ? (big - shd) : (big + shd);
    araw_d.nan  = bn | sn | (bi & si & (bg[31] ^ sm[31]));
    araw_d.inf  = bi | si;
    araw_d.sig  = sum;
    araw_d.expo = ebb;
    if (sum == 48'd0) begin
      araw_d.sgn = bg[31] & sm[31];
    end else begin
      araw_d.sgn = bg[31];
    end
  end

  always_ff @(posedge clk_i) begin
    mraw_q <= mraw_d;
    prod_q <= fp_finish(mraw_q);
    araw_q <= araw_d;
  end

  assign sum_o = fp_finish(araw_q);

endmodule

[hdl/fmt_ctrl.sv]
// ----------------------------------------------------------------------------
// fmt_ctrl
// Sequencer of the update: per C element one read, cols_n multiply-add
// rounds through ARD, MUL, MRND, ADD and ARND, one write back.
// ----------------------------------------------------------------------------
module fmt_ctrl import fmt_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o,
  output logic  busy_o
);

  state_e state_d, state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (start_i) state_d = ST_CRD;
      ST_CRD:  state_d = ST_CLD;
      ST_CLD:  state_d = ST_ARD;
      ST_ARD:  state_d = ST_MUL;
      ST_MUL:  state_d = ST_MRND;
      ST_MRND: state_d = ST_ADD;
      ST_ADD:  state_d = ST_ARND;
      ST_ARND: state_d = stat_i.last_k ? ST_CWR : ST_ARD;
      ST_CWR:  state_d = (stat_i.last_i && stat_i.last_j) ? ST_IDLE : ST_CRD;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = (state_q != ST_IDLE);
    unique case (state_q)
      ST_IDLE: cmd_o.ij_clr = start_i;
      ST_CRD: begin
        cmd_o.c_rd  = 1'b1;
        cmd_o.k_clr = 1'b1;
      end
      ST_CLD:  cmd_o.acc_ld_c = 1'b1;
      ST_ARD:  cmd_o.a_rd = 1'b1;
      ST_MUL, ST_MRND, ST_ADD: ;
      ST_ARND: begin
        cmd_o.acc_ld_sum = 1'b1;
        cmd_o.k_inc      = !stat_i.last_k;
      end
      ST_CWR: begin
        cmd_o.c_wr   = 1'b1;
        cmd_o.ij_inc = !(stat_i.last_i && stat_i.last_j);
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

[hdl/fmt_datapath.sv]
// ----------------------------------------------------------------------------
// fmt_datapath
// A and C stores, index counters, accumulator and the float unit.
// ----------------------------------------------------------------------------
module fmt_datapath import fmt_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [DIM_REG_W-1:0] rows_i,
  input  logic [DIM_REG_W-1:0] cols_i,
  input  cmd_t                 cmd_i,
  output stat_t                stat_o,
  input  logic                 host_we_a_i,
  input  logic                 host_we_c_i,
  input  logic                 host_rd_c_i,
  input  logic [ADDR_W-1:0]    host_addr_i,
  input  logic [DATA_W-1:0]    host_wdata_i,
  output logic [DATA_W-1:0]    c_rdata_o
);

  logic [DATA_W-1:0] a_mem [A_DEPTH];
  logic [DATA_W-1:0] c_mem [C_DEPTH];

  logic [ROWS_W-1:0] m_dim;
  logic [COLS_W-1:0] n_dim;
  logic [IDX_W-1:0]  i_q, j_q;
  logic [K_W-1:0]    k_q;
  logic [A_AW-1:0]   kofs_q;
  logic [C_AW-1:0]   jofs_q;
  logic [DATA_W-1:0] ax_q, ay_q, acc_q, c_rdata_q, sum;
  logic [A_AW-1:0]   ax_addr, ay_addr;
  logic [C_AW-1:0]   ci_addr, c_addr, c_waddr;
  logic [DATA_W-1:0] c_wdata;

  // clamp the dimensions to 1..MAX
  always_comb begin
    if (rows_i == '0) begin
      m_dim = ROWS_W'(1);
    end else if (32'(rows_i) > MAX_ROWS) begin
      m_dim = ROWS_W'(MAX_ROWS);
    end else begin
      m_dim = ROWS_W'(rows_i);
    end
    if (cols_i == '0) begin
      n_dim = COLS_W'(1);
    end else if (32'(cols_i) > MAX_COLS) begin
      n_dim = COLS_W'(MAX_COLS);
    end else begin
      n_dim = COLS_W'(cols_i);
    end
  end

  assign stat_o.last_k = (32'(k_q) == 32'(n_dim) - 1);
  assign stat_o.last_i = (32'(i_q) == 32'(m_dim) - 1);
  assign stat_o.last_j = (32'(j_q) == 32'(m_dim) - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q    <= '0;
      j_q    <= '0;
      k_q    <= '0;
      kofs_q <= '0;
      jofs_q <= '0;
    end else begin
      if (cmd_i.ij_clr) begin
        i_q    <= '0;
        j_q    <= '0;
        jofs_q <= '0;
      end else if (cmd_i.ij_inc) begin
        if (stat_o.last_i) begin
          i_q    <= '0;
          j_q    <= j_q + IDX_W'(1);
          jofs_q <= jofs_q + C_AW'(m_dim);
        end else begin
          i_q <= i_q + IDX_W'(1);
        end
      end
      if (cmd_i.k_clr) begin
        k_q    <= '0;
        kofs_q <= '0;
      end else if (cmd_i.k_inc) begin
        k_q    <= k_q + K_W'(1);
        kofs_q <= kofs_q + A_AW'(m_dim);
      end
    end
  end

  assign ax_addr = A_AW'(i_q) + kofs_q;
  assign ay_addr = A_AW'(j_q) + kofs_q;
  assign ci_addr = C_AW'(i_q) + jofs_q;

  always_ff @(posedge clk_i) begin
    if (host_we_a_i) a_mem[A_AW'(host_addr_i)] <= host_wdata_i;
    if (cmd_i.a_rd) begin
      ax_q <= a_mem[ax_addr];
      ay_q <= a_mem[ay_addr];
    end
  end

  assign c_addr  = cmd_i.c_rd ? ci_addr : C_AW'(host_addr_i);
  assign c_waddr = cmd_i.c_wr ? ci_addr : C_AW'(host_addr_i);
  assign c_wdata = cmd_i.c_wr ? acc_q : host_wdata_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.c_wr || host_we_c_i) c_mem[c_waddr] <= c_wdata;
    if (cmd_i.c_rd || host_rd_c_i) c_rdata_q <= c_mem[c_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_ld_c) begin
      acc_q <= c_rdata_q;
    end else if (cmd_i.acc_ld_sum) begin
      acc_q <= sum;
    end
  end

  fmt_fpu u_fpu (
    .clk_i  (clk_i),
    .op_x_i (ax_q),
    .op_y_i (ay_q),
    .acc_i  (acc_q),
    .sum_o  (sum)
  );

  assign c_rdata_o = c_rdata_q;

endmodule

[hdl/float_matrix_times_own_transpose.sv]
// ----------------------------------------------------------------------------
// float_matrix_times_own_transpose
// C += A * A^T in binary32 over a column-major A and square C.
// ----------------------------------------------------------------------------
// A write of A or C is taken whenever the block is not computing, no read is
// pending and the output is not stalled; a read of C blocks the input while
// the single C read port delivers, and its result sits in an output register.
// A compute word runs rows_m * rows_m C elements, each a read and load of C,
// cols_n multiply, round, add, round loops around the accumulator (each with
// its A read) and a write back of the C element; no word is taken meanwhile.
module float_matrix_times_own_transpose import fmt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,   // addr[11:0], value[43:12], zero pad
  input  logic [1:0]  s_axis_tuser_i,   // kind[1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,   // c_value[31:0], c_addr[43:32], zero pad
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  logic [DIM_REG_W-1:0] rows_q, cols_q;
  logic                 pend_q, pend_oor_q, out_valid_q;
  logic [ADDR_W-1:0]    pend_addr_q, out_addr_q;
  logic [DATA_W-1:0]    out_value_q, c_rdata;
  logic                 busy, in_acc, start;
  logic                 we_a, we_c, rd_c;
  logic [ADDR_W-1:0]    addr;
  logic [DATA_W-1:0]    value;
  kind_e                kind;
  cmd_t                 cmd;
  stat_t                stat;

  assign addr  = s_axis_tdata_i[ADDR_W-1:0];
  assign value = s_axis_tdata_i[ADDR_W+DATA_W-1:ADDR_W];
  assign kind  = kind_e'(s_axis_tuser_i);

  assign s_axis_tready_o = !busy && !pend_q && !(out_valid_q && !m_axis_tready_i);
  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;
  assign we_a  = in_acc && (kind == KIND_WR_A) && (32'(addr) < A_DEPTH);
  assign we_c  = in_acc && (kind == KIND_WR_C) && (32'(addr) < C_DEPTH);
  assign rd_c  = in_acc && (kind == KIND_RD_C);
  assign start = in_acc && (kind == KIND_COMPUTE);

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= DIM_REG_W'(64);
      cols_q <= DIM_REG_W'(64);
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_ROWS) rows_q <= cfg_data_i[DIM_REG_W-1:0];
      if (cfg_index_i == CFG_COLS) cols_q <= cfg_data_i[DIM_REG_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q <= rd_c;
      if (pend_q) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_c) begin
      pend_addr_q <= addr;
      pend_oor_q  <= !(32'(addr) < C_DEPTH);
    end
    if (pend_q) begin
      out_addr_q  <= pend_addr_q;
      out_value_q <= pend_oor_q ? '0 : c_rdata;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'd0, out_addr_q, out_value_q};

  fmt_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  fmt_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rows_i       (rows_q),
    .cols_i       (cols_q),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .host_we_a_i  (we_a),
    .host_we_c_i  (we_c),
    .host_rd_c_i  (rd_c),
    .host_addr_i  (addr),
    .host_wdata_i (value),
    .c_rdata_o    (c_rdata)
  );

endmodule

[hdl/fmt_checker.sv]
// ----------------------------------------------------------------------------
// fmt_checker
// Port-level checks of the read path and the compute stall.
// ----------------------------------------------------------------------------
module fmt_checker import fmt_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [47:0] s_axis_tdata_i,
  input logic [1:0]  s_axis_tuser_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [47:0] m_axis_tdata_o
);

  logic rd_acc, cmp_acc;
  assign rd_acc  = s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i == KIND_RD_C);
  assign cmp_acc = s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i == KIND_COMPUTE);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result word dropped while stalled");

  a_rd_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_acc |=> ##1 (m_axis_tvalid_o &&
                    m_axis_tdata_o[43:32] == $past(s_axis_tdata_i[11:0], 2)))
    else $error("read result missing or wrong address");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(rd_acc, 2))
    else $error("result word without a read");

  a_cmp_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmp_acc |=> !s_axis_tready_o)
    else $error("input taken during compute");

endmodule

bind float_matrix_times_own_transpose fmt_checker u_chk (.*);

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the A times A-transpose engine: loads A and C over
// the input stream, issues updates and reads, and checks every returned C
// word against a binary32 predictor kept in the bench.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import fmt_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] value;
  } c_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [47:0] s_axis_tdata_i = '0;
  logic [1:0]  s_axis_tuser_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [47:0] m_axis_tdata_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  float_matrix_times_own_transpose dut (.*);

  // bench copy of the block state
  logic [DATA_W-1:0] a_mem [A_DEPTH];
  logic [DATA_W-1:0] c_mem [C_DEPTH];
  logic [DIM_REG_W-1:0] rows_reg = 7'd64;
  logic [DIM_REG_W-1:0] cols_reg = 7'd64;
  c_word_t c_reads_due [$];
  int     c_written_list [$];

  int     errors = 0;
  int     n_items = 0;
  int     n_reads = 0;
  int     n_updates = 0;
  int     cycles = 0;
  bit     no_idle = 1'b0;

  initial forever #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILURE");
      $finish;
    end
  end

  // ---- binary32 arithmetic through exact double values ----
  function automatic real f32_to_real(logic [31:0] f);
    logic [10:0] de;
    real v;
    if (f[30:23] == 8'hFF) begin
      if (f[22:0] != 0) return $bitstoreal(64'h7FF8_0000_0000_0000);
      return $bitstoreal({f[31], 11'h7FF, 52'h0});
    end
    if (f[30:23] == 8'h00) begin
      if (f[22:0] == 0) return $bitstoreal({f[31], 63'h0});
      v = real'(f[22:0]) * $bitstoreal({1'b0, 11'd874, 52'h0});
      return f[31] ? -v : v;
    end
    de = {3'b0, f[30:23]} + 11'd896;
    return $bitstoreal({f[31], de, f[22:0], 29'h0});
  endfunction

  // round a double to binary32, nearest even, subnormals kept
  function automatic logic [31:0] real_to_f32(real r);
    logic [63:0] d;
    logic s;
    int e, e32, sh, base;
    longint unsigned sig, q, rem, half, mag;
    d = $realtobits(r);
    s = d[63];
    e = int'(d[62:52]);
    if (e == 2047) return (d[51:0] != 0) ? QNAN : {s, 8'hFF, 23'h0};
    if (e == 0) return {s, 31'h0};
    e32 = e - 1023 + 127;
    sig = {11'b0, 1'b1, d[51:0]};
    sh = 29 + ((e32 < 1) ? (1 - e32) : 0);
    if (sh > 60) return {s, 31'h0};
    q = sig >> sh;
    rem = sig & ((64'd1 << sh) - 1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && q[0])) q = q + 1;
    base = (e32 >= 1) ? e32 - 1 : 0;
    mag = (longint'(base) << 23) + q;
    if (mag >= 64'h7F80_0000) return {s, 8'hFF, 23'h0};
    return {s, mag[30:0]};
  endfunction

  function automatic int clamp_dim(logic [DIM_REG_W-1:0] v, int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return int'(v);
  endfunction

  task automatic update_c_predict();
    int m, n, ci;
    logic [31:0] acc, prod;
    m = clamp_dim(rows_reg, MAX_ROWS);
    n = clamp_dim(cols_reg, MAX_COLS);
    for (int j = 0; j < m; j++)
      for (int i = 0; i < m; i++) begin
        ci = i + j * m;
        acc = c_mem[ci];
        for (int k = 0; k < n; k++) begin
          prod = real_to_f32(f32_to_real(a_mem[i + k * m]) * f32_to_real(a_mem[j + k * m]));
          acc = real_to_f32(f32_to_real(acc) + f32_to_real(prod));
        end
        c_mem[ci] = acc;
      end
  endtask

  // ---- drivers ----
  task automatic send_word(kind_e kind, int addr, logic [31:0] value);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= kind;
    s_axis_tdata_i  <= {4'b0, value, addr[ADDR_W-1:0]};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    n_items++;
    case (kind)
      KIND_WR_A: a_mem[addr] = value;
      KIND_WR_C: begin
        c_mem[addr] = value;
        c_written_list.push_back(addr);
      end
      KIND_COMPUTE: begin
        update_c_predict();
        n_updates++;
      end
      KIND_RD_C: begin
        c_reads_due.push_back('{addr: addr[ADDR_W-1:0], value: c_mem[addr]});
        n_reads++;
      end
    endcase
  endtask

  // park the input, let the block drain, then let it settle
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (c_reads_due.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [7:0] index, logic [31:0] data);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (index == CFG_ROWS) rows_reg = data[DIM_REG_W-1:0];
    else if (index == CFG_COLS) cols_reg = data[DIM_REG_W-1:0];
  endtask

  task automatic report_mismatch(string msg);
    errors++;
    if (errors <= 40) $display("mismatch @%0d: %s", cycles, msg);
  endtask

  always @(posedge clk_i) begin
    c_word_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (c_reads_due.size() == 0) begin
        report_mismatch($sformatf("unexpected word addr %0d", m_axis_tdata_o[43:32]));
      end else begin
        want = c_reads_due.pop_front();
        if (m_axis_tdata_o[43:32] != want.addr)
          report_mismatch($sformatf("c_addr got %0d want %0d", m_axis_tdata_o[43:32], want.addr));
        if (m_axis_tdata_o[31:0] != want.value)
          report_mismatch($sformatf("c_value at %0d got %h want %h", want.addr,
                                    m_axis_tdata_o[31:0], want.value));
      end
    end
  end

  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      if (no_idle) begin
        m_axis_tready_i <= 1'b1;
        @(posedge clk_i);
      end else begin
        n = $urandom_range(0, 10);
        if (n > 0) begin
          m_axis_tready_i <= 1'b0;
          repeat (n) @(posedge clk_i);
        end
        m_axis_tready_i <= 1'b1;
        @(posedge clk_i);
        while (!m_axis_tvalid_o) @(posedge clk_i);
      end
    end
  end

  // ---- operand generation ----
  function automatic logic [31:0] rand_float();
    logic [31:0] f;
    f = $urandom;
    case ($urandom_range(0, 9))
      0: ;
      1: case ($urandom_range(0, 5))
           0: f = {f[31], 31'h0};
           1: f = {f[31], 8'hFF, 23'h0};
           2: f = {f[31], 8'hFF, f[22:0] | 23'h1};
           3: f = {f[31], 8'h00, f[22:0]};
           4: f = {f[31], 8'hFE, 23'h7FFFFF};
           default: f = {f[31], 8'h01, f[22:0]};
         endcase
      2: f[30:23] = 8'($urandom_range(1, 30));
      3: f[30:23] = 8'($urandom_range(200, 254));
      default: f[30:23] = 8'($urandom_range(120, 134));
    endcase
    return f;
  endfunction

  task automatic fill_operands();
    int m, n;
    m = clamp_dim(rows_reg, MAX_ROWS);
    n = clamp_dim(cols_reg, MAX_COLS);
    for (int x = 0; x < m * n; x++) send_word(KIND_WR_A, x, rand_float());
    for (int x = 0; x < m * m; x++) send_word(KIND_WR_C, x, rand_float());
  endtask

  task automatic read_all_c();
    int m;
    m = clamp_dim(rows_reg, MAX_ROWS);
    for (int x = 0; x < m * m; x++) send_word(KIND_RD_C, x, $urandom);
  endtask

  // ---- tests ----
  task automatic test_default_dims();
    // reset sizes: plain load and read back at both ends of the address range
    send_word(KIND_WR_C, 0, 32'h3F80_0000);
    send_word(KIND_WR_C, 4095, 32'hFFFF_FFFF);
    send_word(KIND_WR_A, 4095, 32'h0000_0000);
    send_word(KIND_RD_C, 4095, 32'hFFFF_FFFF);
    send_word(KIND_RD_C, 0, 32'h0);
    drain();
  endtask

  task automatic test_special_values();
    write_reg(CFG_ROWS, 32'd2);
    write_reg(CFG_COLS, 32'd2);
    // inf times zero, overflow, subnormal products, signed zeros
    send_word(KIND_WR_A, 0, 32'h7F80_0000);
    send_word(KIND_WR_A, 1, 32'h0000_0000);
    send_word(KIND_WR_A, 2, 32'h0000_0001);
    send_word(KIND_WR_A, 3, 32'h7F7F_FFFF);
    send_word(KIND_WR_C, 0, 32'h8000_0000);
    send_word(KIND_WR_C, 1, 32'hFF80_0000);
    send_word(KIND_WR_C, 2, 32'h0080_0000);
    send_word(KIND_WR_C, 3, 32'h7FFF_FFFF);
    send_word(KIND_COMPUTE, 0, 32'h0);
    read_all_c();
    // tie-to-even and cancellation
    send_word(KIND_WR_A, 0, 32'h3F80_0001);
    send_word(KIND_WR_A, 1, 32'hBF80_0000);
    send_word(KIND_WR_A, 2, 32'h2000_0000);
    send_word(KIND_WR_A, 3, 32'h8080_0000);
    send_word(KIND_WR_C, 0, 32'hBF80_0002);
    send_word(KIND_COMPUTE, 4095, 32'hFFFF_FFFF);
    read_all_c();
    drain();
  endtask

  task automatic test_clamped_dims();
    // zero rows clamp to one row, 127 columns clamp to the maximum
    write_reg(CFG_ROWS, 32'd0);
    write_reg(CFG_COLS, 32'd127);
    no_idle = 1'b1;
    fill_operands();
    send_word(KIND_COMPUTE, 0, 32'h0);
    no_idle = 1'b0;
    for (int x = 0; x < 20; x++)
      send_word(KIND_RD_C, c_written_list[$urandom_range(0, c_written_list.size() - 1)],
                32'h0);
    send_word(KIND_RD_C, 4095, 32'h0);
    drain();
  endtask

  task automatic test_longest_dot();
    write_reg(CFG_ROWS, 32'd1);
    write_reg(CFG_COLS, 32'd64);
    fill_operands();
    send_word(KIND_COMPUTE, 0, 32'h0);
    send_word(KIND_RD_C, 0, 32'h0);
    // an index past the register list changes nothing
    write_reg(8'd2, 32'hFFFF_FFFF);
    write_reg(8'hFF, 32'h0);
    send_word(KIND_COMPUTE, 0, 32'h0);
    send_word(KIND_RD_C, 0, 32'h0);
    drain();
  endtask

  task automatic test_random_phases();
    int m, x, pick;
    for (int ph = 0; ph < 8; ph++) begin
      // bits above the register width are dropped
      write_reg(CFG_ROWS, ({$urandom} & 32'hFFFF_FF80) | 32'($urandom_range(1, 6)));
      write_reg(CFG_COLS, 32'($urandom_range(1, 6)));
      no_idle = (ph % 4 == 3);
      m = clamp_dim(rows_reg, MAX_ROWS);
      fill_operands();
      for (int it = 0; it < 25; it++) begin
        pick = $urandom_range(0, 9);
        if (pick < 2) begin
          send_word(KIND_WR_A, $urandom_range(0, 4095), rand_float());
        end else if (pick < 4) begin
          x = ($urandom_range(0, 1)) ? $urandom_range(0, m * m - 1) : $urandom_range(0, 4095);
          send_word(KIND_WR_C, x, rand_float());
        end else if (pick == 4) begin
          send_word(KIND_COMPUTE, $urandom_range(0, 4095), $urandom);
        end else begin
          if ($urandom_range(0, 3) == 0)
            x = c_written_list[$urandom_range(0, c_written_list.size() - 1)];
          else
            x = $urandom_range(0, m * m - 1);
          send_word(KIND_RD_C, x, $urandom);
        end
      end
      send_word(KIND_RD_C, 0, 32'h0);
    end
    no_idle = 1'b0;
    drain();
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_dims();
    test_special_values();
    test_clamped_dims();
    test_longest_dot();
    test_random_phases();
    drain();
    repeat (50) @(posedge clk_i);
    $display("covered %0d words: %0d updates, %0d C reads checked", n_items, n_updates, n_reads);
    $display("register clamps at both ends, small square sizes, dot products up to 64 terms,");
    $display("IEEE special values and stalls on both sides");
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[files.f]
hdl/fmt_pkg.sv
hdl/fmt_fpu.sv
hdl/fmt_ctrl.sv
hdl/fmt_datapath.sv
hdl/float_matrix_times_own_transpose.sv
hdl/fmt_checker.sv
dv/testbench.sv
